// ===== hw/rtl/dbd_pkg.sv =====
// dbd_pkg: shared types, register codes and arithmetic helpers for the dxt block decoder
// no dependencies; imported by every module of the block
package dbd_pkg;

  typedef struct packed {
    logic [63:0] alpha_block;
    logic [63:0] color_block;
  } in_item_t;

  typedef struct packed {
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
    logic [7:0]  alpha;
    logic [11:0] pixel_x;
    logic [11:0] pixel_y;
    logic        last_texel;
  } out_item_t;

  typedef struct packed {
    logic        format_mode;
    logic [12:0] image_width;
    logic [12:0] image_height;
  } cfg_t;

  // one classified block waiting for the back end
  typedef struct packed {
    in_item_t    blk;
    logic        dxt5;
    logic [9:0]  base_x;
    logic [9:0]  base_y;
    logic [3:0]  col_mask;
    logic [3:0]  row_mask;
  } blk_entry_t;

  localparam int QDEPTH = 2;

  localparam logic [1:0] REG_FORMAT = 2'd0;
  localparam logic [1:0] REG_WIDTH  = 2'd1;
  localparam logic [1:0] REG_HEIGHT = 2'd2;

  localparam logic        FORMAT_RST = 1'b0;
  localparam logic [12:0] DIM_RST    = 13'd4;

  // reciprocals for exact truncating division by small constants
  localparam logic [15:0] RCP31 = 16'd33826;  // 2^20 / 31, rounded up
  localparam logic [15:0] RCP63 = 16'd16645;  // 2^20 / 63, rounded up
  localparam logic [15:0] RCP3  = 16'd1366;   // 2^12 / 3, rounded up
  localparam logic [15:0] RCP7  = 16'd9363;   // 2^16 / 7, rounded up
  localparam logic [15:0] RCP5  = 16'd13108;  // 2^16 / 5, rounded up

  // c * 255 / 31, truncated
  function automatic logic [7:0] expand5(input logic [4:0] c);
    logic [12:0] x;
    logic [28:0] p;
    x = {c, 8'b0} - 13'(c);
    p = 29'(x) * 29'(RCP31);
    return p[27:20];
  endfunction

  // c * 255 / 63, truncated
  function automatic logic [7:0] expand6(input logic [5:0] c);
    logic [13:0] x;
    logic [29:0] p;
    x = {c, 8'b0} - 14'(c);
    p = 30'(x) * 30'(RCP63);
    return p[27:20];
  endfunction

  // x / 3 for x up to 765
  function automatic logic [7:0] div3(input logic [9:0] x);
    logic [25:0] p;
    p = 26'(x) * 26'(RCP3);
    return p[19:12];
  endfunction

  // num / 7 or num / 5 for the alpha palette
  function automatic logic [7:0] div_alpha(input logic [10:0] num, input logic seven);
    logic [15:0] m;
    logic [26:0] p;
    m = seven ? RCP7 : RCP5;
    p = 27'(num) * 27'(m);
    return p[23:16];
  endfunction

  // position of the lowest set bit
  function automatic logic [3:0] first_set(input logic [15:0] m);
    logic [3:0] idx;
    idx = '0;
    for (int i = 15; i >= 0; i--) begin
      if (m[i]) idx = 4'(i);
    end
    return idx;
  endfunction

endpackage

// ===== hw/rtl/dbd_cfg.sv =====
// dbd_cfg: apb register file holding format and image size
// depends on dbd_pkg
module dbd_cfg
  import dbd_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  output cfg_t        cfg
);

  cfg_t cfg_r;
  cfg_t cfg_nxt;

  assign pready = 1'b1;
  assign cfg    = cfg_r;

  always_comb begin
    cfg_nxt = cfg_r;
    if (psel && penable && pwrite) begin
      case (paddr[3:2])
        REG_FORMAT: cfg_nxt.format_mode  = pwdata[0];
        REG_WIDTH:  cfg_nxt.image_width  = pwdata[12:0];
        REG_HEIGHT: cfg_nxt.image_height = pwdata[12:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.format_mode  <= FORMAT_RST;
      cfg_r.image_width  <= DIM_RST;
      cfg_r.image_height <= DIM_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  always_comb begin
    case (paddr[3:2])
      REG_FORMAT: prdata = {31'b0, cfg_r.format_mode};
      REG_WIDTH:  prdata = {19'b0, cfg_r.image_width};
      REG_HEIGHT: prdata = {19'b0, cfg_r.image_height};
      default:    prdata = '0;
    endcase
  end

endmodule

// ===== hw/rtl/dbd_front.sv =====
// dbd_front: accepts blocks, tracks the block position and works out texel clipping
// depends on dbd_pkg; feeds dbd_fifo
module dbd_front
  import dbd_pkg::*;
#(
  parameter int MAX_IMAGE_DIM = 4096
) (
  input  logic       clk,
  input  logic       rst_n,
  input  cfg_t       cfg,
  input  logic       in_valid,
  output logic       in_ready,
  input  in_item_t   in_data,
  input  logic       q_full,
  output logic       q_push,
  output blk_entry_t q_entry
);

  localparam int CW  = $clog2(MAX_IMAGE_DIM + 1);
  localparam int BPW = (MAX_IMAGE_DIM > 4) ? $clog2((MAX_IMAGE_DIM + 3) / 4) : 1;

  logic [BPW-1:0] col_r, col_nxt;
  logic [BPW-1:0] row_r, row_nxt;
  logic [CW-1:0]  w, h;
  logic [CW:0]    w_p3, h_p3;
  logic [BPW:0]   bw, bh;
  logic [BPW:0]   col_inc, row_inc;
  logic [3:0]     col_mask, row_mask;

  // zero reads as one, anything past the maximum as the maximum
  always_comb begin
    if (cfg.image_width == '0) w = CW'(1);
    else if (32'(cfg.image_width) > 32'(MAX_IMAGE_DIM)) w = CW'(MAX_IMAGE_DIM);
    else w = CW'(cfg.image_width);
    if (cfg.image_height == '0) h = CW'(1);
    else if (32'(cfg.image_height) > 32'(MAX_IMAGE_DIM)) h = CW'(MAX_IMAGE_DIM);
    else h = CW'(cfg.image_height);
  end

  assign w_p3 = {1'b0, w} + (CW+1)'(3);
  assign h_p3 = {1'b0, h} + (CW+1)'(3);
  assign bw   = (BPW+1)'(w_p3 >> 2);
  assign bh   = (BPW+1)'(h_p3 >> 2);

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      col_mask[i] = (32'({col_r, 2'b00}) + 32'(i)) < 32'(w);
      row_mask[i] = (32'({row_r, 2'b00}) + 32'(i)) < 32'(h);
    end
  end

  assign in_ready = !q_full;
  assign q_push   = in_valid && !q_full;

  always_comb begin
    q_entry.blk      = in_data;
    q_entry.dxt5     = cfg.format_mode;
    q_entry.base_x   = 10'(col_r);
    q_entry.base_y   = 10'(row_r);
    q_entry.col_mask = col_mask;
    q_entry.row_mask = row_mask;
  end

  // raster walk over blocks, wrapping at the row and frame end
  always_comb begin
    col_inc = {1'b0, col_r} + (BPW+1)'(1);
    row_inc = {1'b0, row_r} + (BPW+1)'(1);
    col_nxt = col_r;
    row_nxt = row_r;
    if (q_push) begin
      if (col_inc >= bw) begin
        col_nxt = '0;
        if (row_inc >= bh) row_nxt = '0;
        else row_nxt = row_inc[BPW-1:0];
      end else begin
        col_nxt = col_inc[BPW-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
    end else begin
      col_r <= col_nxt;
      row_r <= row_nxt;
    end
  end

endmodule

// ===== hw/rtl/dbd_fifo.sv =====
// dbd_fifo: short queue of classified blocks between front and back end
// depends on dbd_pkg
module dbd_fifo
  import dbd_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       push,
  input  blk_entry_t wr_entry,
  output logic       full,
  output logic       rd_valid,
  input  logic       pop,
  output blk_entry_t rd_entry
);

  localparam int PW = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int NW = $clog2(QDEPTH + 1);

  blk_entry_t    mem [QDEPTH];
  logic [PW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [NW-1:0] count_r, count_nxt;
  logic          do_pop;

  assign full     = count_r == NW'(QDEPTH);
  assign rd_valid = count_r != '0;
  assign rd_entry = mem[rd_ptr_r];
  assign do_pop   = pop && rd_valid;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(QDEPTH - 1)) ? '0 : wr_ptr_r + PW'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(QDEPTH - 1)) ? '0 : rd_ptr_r + PW'(1);
    end
    if (push && !do_pop) count_nxt = count_r + NW'(1);
    else if (!push && do_pop) count_nxt = count_r - NW'(1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr_r] <= wr_entry;
  end

endmodule

// ===== hw/rtl/dbd_back.sv =====
// dbd_back: builds colour and alpha palettes, emits visible texels one per cycle when
// out_ready allows; depends on dbd_pkg; drains dbd_fifo, drives the output register
module dbd_back
  import dbd_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       q_valid,
  input  blk_entry_t q_entry,
  output logic       q_pop,
  output logic       out_valid,
  input  logic       out_ready,
  output out_item_t  out_data
);

  typedef struct packed {
    logic [2:0][7:0]  e0;
    logic [2:0][7:0]  e1;
    logic             four;
    logic             dxt5;
    logic [7:0]       a0;
    logic [7:0]       a1;
    logic             a_gt;
    logic [5:0][10:0] anum;
    logic [31:0]      cidx;
    logic [47:0]      aidx;
    logic [9:0]       base_x;
    logic [9:0]       base_y;
    logic [15:0]      mask;
  } s1_t;

  // stage 1: endpoint expansion and alpha weighted sums
  s1_t  s1_r, s1_d;
  logic s1_valid_r, s1_valid_nxt;
  logic s1_take;

  // stage 2: palettes and the texel walk
  logic [3:0][3:0][7:0] pal_r, pal_d;   // [index][r,g,b,a]
  logic [7:0][7:0]      apal_r, apal_d;
  logic [31:0]          em_cidx_r;
  logic [47:0]          em_aidx_r;
  logic                 em_dxt5_r;
  logic [9:0]           em_bx_r, em_by_r;
  logic [15:0]          em_mask_r, em_mask_nxt;
  logic                 em_valid_r, em_valid_nxt;
  logic                 em_take, em_go, em_last;

  out_item_t out_r, out_d;
  logic      out_valid_r, out_valid_nxt;
  logic      out_take;

  logic [3:0]  p;
  logic [15:0] rest;
  logic [1:0]  ci;
  logic [5:0]  ai_pos;
  logic [2:0]  ai;

  always_comb begin
    logic [15:0] c0, c1;
    c0 = q_entry.blk.color_block[15:0];
    c1 = q_entry.blk.color_block[31:16];
    s1_d.e0[2] = expand5(c0[15:11]);
    s1_d.e0[1] = expand6(c0[10:5]);
    s1_d.e0[0] = expand5(c0[4:0]);
    s1_d.e1[2] = expand5(c1[15:11]);
    s1_d.e1[1] = expand6(c1[10:5]);
    s1_d.e1[0] = expand5(c1[4:0]);
    s1_d.four  = q_entry.dxt5 || (c0 > c1);
    s1_d.dxt5  = q_entry.dxt5;
    s1_d.a0    = q_entry.blk.alpha_block[7:0];
    s1_d.a1    = q_entry.blk.alpha_block[15:8];
    s1_d.a_gt  = s1_d.a0 > s1_d.a1;
    for (int k = 1; k <= 6; k++) begin
      if (s1_d.a_gt) begin
        s1_d.anum[k-1] = 11'(11'(7 - k) * 11'(s1_d.a0) + 11'(k) * 11'(s1_d.a1));
      end else if (k <= 4) begin
        s1_d.anum[k-1] = 11'(11'(5 - k) * 11'(s1_d.a0) + 11'(k) * 11'(s1_d.a1));
      end else begin
        s1_d.anum[k-1] = '0;
      end
    end
    s1_d.cidx   = q_entry.blk.color_block[63:32];
    s1_d.aidx   = q_entry.blk.alpha_block[63:16];
    s1_d.base_x = q_entry.base_x;
    s1_d.base_y = q_entry.base_y;
    for (int y = 0; y < 4; y++) begin
      for (int x = 0; x < 4; x++) begin
        s1_d.mask[4*y+x] = q_entry.row_mask[y] && q_entry.col_mask[x];
      end
    end
  end

  // palette division by constants
  always_comb begin
    pal_d[0] = {s1_r.e0, 8'hFF};
    pal_d[1] = {s1_r.e1, 8'hFF};
    pal_d[2][0] = 8'hFF;
    pal_d[3][0] = s1_r.four ? 8'hFF : 8'h00;
    for (int ch = 0; ch < 3; ch++) begin
      if (s1_r.four) begin
        pal_d[2][ch+1] = div3(10'({s1_r.e0[ch], 1'b0}) + 10'(s1_r.e1[ch]));
        pal_d[3][ch+1] = div3(10'(s1_r.e0[ch]) + 10'({s1_r.e1[ch], 1'b0}));
      end else begin
        pal_d[2][ch+1] = 8'((9'(s1_r.e0[ch]) + 9'(s1_r.e1[ch])) >> 1);
        pal_d[3][ch+1] = 8'h00;
      end
    end
    apal_d[0] = s1_r.a0;
    apal_d[1] = s1_r.a1;
    for (int k = 1; k <= 6; k++) begin
      if (s1_r.a_gt || k <= 4) apal_d[k+1] = div_alpha(s1_r.anum[k-1], s1_r.a_gt);
      else if (k == 5) apal_d[k+1] = 8'h00;
      else apal_d[k+1] = 8'hFF;
    end
  end

  // texel pick: lowest visible texel still pending
  assign p      = first_set(em_mask_r);
  assign rest   = em_mask_r & ~(16'(1) << p);
  assign em_last = rest == '0;
  assign ci     = em_cidx_r[{p, 1'b0} +: 2];
  assign ai_pos = 6'({p, 1'b0}) + 6'(p);
  assign ai     = em_aidx_r[ai_pos +: 3];

  assign out_take = !out_valid_r || out_ready;
  assign em_go    = em_valid_r && out_take;
  assign em_take  = !em_valid_r || (em_go && em_last);
  assign s1_take  = !s1_valid_r || em_take;
  assign q_pop    = q_valid && s1_take;

  always_comb begin
    out_d.red        = pal_r[ci][3];
    out_d.green      = pal_r[ci][2];
    out_d.blue       = pal_r[ci][1];
    out_d.alpha      = em_dxt5_r ? apal_r[ai] : pal_r[ci][0];
    out_d.pixel_x    = {em_bx_r, p[1:0]};
    out_d.pixel_y    = {em_by_r, p[3:2]};
    out_d.last_texel = em_last;
  end

  always_comb begin
    s1_valid_nxt  = s1_take ? q_valid : s1_valid_r;
    em_valid_nxt  = em_take ? (s1_valid_r && (s1_r.mask != '0)) : em_valid_r;
    out_valid_nxt = out_take ? em_valid_r : out_valid_r;
    if (em_take) em_mask_nxt = s1_r.mask;
    else if (em_go) em_mask_nxt = rest;
    else em_mask_nxt = em_mask_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      em_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      em_valid_r  <= em_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_take) s1_r <= s1_d;
    em_mask_r <= em_mask_nxt;
    if (em_take) begin
      pal_r     <= pal_d;
      apal_r    <= apal_d;
      em_cidx_r <= s1_r.cidx;
      em_aidx_r <= s1_r.aidx;
      em_dxt5_r <= s1_r.dxt5;
      em_bx_r   <= s1_r.base_x;
      em_by_r   <= s1_r.base_y;
    end
    if (em_go) out_r <= out_d;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

// ===== hw/rtl/dxt_block_decoder.sv =====
// dxt_block_decoder: s3tc dxt1 / dxt5 block decoder, top level
// depends on dbd_pkg, dbd_cfg, dbd_front, dbd_fifo, dbd_back
//
// Usage
//   in channel  : one compressed 4x4 block per beat (alpha half, colour half), blocks in
//                 raster block order over the image; valid/ready handshake
//   out channel : one rgba texel per beat with its image coordinates, raster order inside
//                 the block; last_texel marks the final visible texel of a block
//   apb port    : format_mode at 0x0, image_width at 0x4, image_height at 0x8; write
//                 only while the decoder is idle
// Timing
//   first texel of a block passes the queue, stage 1, the palette and emit stage and the
//   output register; one texel per cycle while the receiver is ready; the emit stage steps
//   only through the visible texels of a block, and a block with none emits no texel, so
//   the emit stage walking the visible texel positions sets the block rate
// Reset
//   rst_n (synchronous) empties the pipeline and queue, returns the block position to the
//   top left and loads dxt1 mode with a 4x4 image
// Stall
//   a stalled receiver holds the output register; stage 1, the palette stage and the
//   two-entry queue keep taking blocks until full, then in_ready drops
module dxt_block_decoder
  import dbd_pkg::*;
#(
  parameter int MAX_IMAGE_DIM = 4096
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  in_item_t    in_data,
  output logic        out_valid,
  input  logic        out_ready,
  output out_item_t   out_data,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  cfg_t       cfg;
  logic       q_full;
  logic       q_push;
  blk_entry_t q_wr;
  logic       q_valid;
  logic       q_pop;
  blk_entry_t q_rd;

  dbd_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  dbd_front #(
    .MAX_IMAGE_DIM (MAX_IMAGE_DIM)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_entry  (q_wr)
  );

  dbd_fifo u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .wr_entry (q_wr),
    .full     (q_full),
    .rd_valid (q_valid),
    .pop      (q_pop),
    .rd_entry (q_rd)
  );

  dbd_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_valid),
    .q_entry   (q_rd),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

// ===== hw/rtl/dbd_checker.sv =====
// dbd_checker: port-level assertions for the dxt block decoder, bound to the top level
// depends on dbd_pkg and dxt_block_decoder
module dbd_checker
  import dbd_pkg::*;
(
  input logic      clk,
  input logic      rst_n,
  input logic      in_ready,
  input logic      out_valid,
  input logic      out_ready,
  input out_item_t out_data
);

  // a stalled texel holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("output texel changed while stalled");

  // texels of one block come without gaps
  a_block_burst: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && !out_data.last_texel |=> out_valid)
    else $error("gap inside a block's texel burst");

  // texels before the last one stay in the same 4x4 block
  a_same_block: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && !out_data.last_texel |=>
      out_data.pixel_x[11:2] == $past(out_data.pixel_x[11:2]) &&
      out_data.pixel_y[11:2] == $past(out_data.pixel_y[11:2]))
    else $error("texel left its block before last_texel");

  // reset empties the pipeline and opens the input
  a_reset_clear: assert property (@(posedge clk)
    !rst_n |=> !out_valid && in_ready)
    else $error("pipeline not cleared by reset");

endmodule

bind dxt_block_decoder dbd_checker u_dbd_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);
